FILE: hdl/ssa_pkg.sv
// Shared constants, codes and control types for the sprite slot allocator.
`default_nettype none

package ssa_pkg;

   // Default sizes
   localparam int SLOT_COUNT_DEF  = 128;
   localparam int GROUP_COUNT_DEF = 32;

   // Field widths
   localparam int CMD_W    = 3;
   localparam int ATTR_W   = 48;
   localparam int SLOT_W   = 8;
   localparam int GROUP_W  = 5;
   localparam int COEF_W   = 16;
   localparam int ROT_W    = 4 * COEF_W;
   localparam int STATUS_W = 2;
   localparam int GRANT_W  = 7;

   // Free-slot search is split into chunks of this many bits
   localparam int CHUNK_BITS  = 16;
   localparam int CHUNK_IDX_W = 4;

   // Command codes
   localparam logic [CMD_W-1:0] CMD_ALLOC = 3'd0;
   localparam logic [CMD_W-1:0] CMD_FREE  = 3'd1;
   localparam logic [CMD_W-1:0] CMD_ROT   = 3'd2;
   localparam logic [CMD_W-1:0] CMD_READ  = 3'd3;
   localparam logic [CMD_W-1:0] CMD_CLEAR = 3'd4;

   // Result status codes
   localparam logic [STATUS_W-1:0] RSP_OK        = 2'd0;
   localparam logic [STATUS_W-1:0] RSP_FULL      = 2'd1;
   localparam logic [STATUS_W-1:0] RSP_RANGE     = 2'd2;
   localparam logic [STATUS_W-1:0] RSP_NOT_ALLOC = 2'd3;

   // Controller to datapath
   typedef struct packed {
      logic                capture;
      logic                alloc_wr;
      logic                free_wr;
      logic                rot_wr;
      logic                clear_all;
      logic                read_out;
      logic                alloc_out;
      logic                slot_out;
      logic                rsp_load;
      logic [STATUS_W-1:0] status;
   } ctl_cmd_type;

   // Datapath to controller
   typedef struct packed {
      logic table_full;
      logic slot_in_range;
      logic slot_used;
      logic group_in_range;
   } dp_status_type;

endpackage

`default_nettype wire

FILE: hdl/sprite_slot_allocator_core.sv
// On accept the controller enters its finish state, from which the result registers load.
// A new item waits while busy; busy is high for the one cycle in which the free-slot
// search finishes, the occupancy bitmap is updated and the registered store reads return.
// The result is held for one cycle only; the receiver cannot stall.
// Reset (synchronous) frees every slot and invalidates every rotation group; no sweep of the
// stores follows, so an item can be accepted right after reset.
`default_nettype none

module sprite_slot_allocator_core #(
   parameter int SLOT_COUNT  = ssa_pkg::SLOT_COUNT_DEF,
   parameter int GROUP_COUNT = ssa_pkg::GROUP_COUNT_DEF
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                start,
   output logic                                     busy,
   input  wire logic        [ssa_pkg::CMD_W-1:0]    req_command,
   input  wire logic        [ssa_pkg::ATTR_W-1:0]   req_attributes,
   input  wire logic        [ssa_pkg::SLOT_W-1:0]   req_slot_index,
   input  wire logic        [ssa_pkg::GROUP_W-1:0]  req_group_index,
   input  wire logic signed [ssa_pkg::COEF_W-1:0]   req_coef_a,
   input  wire logic signed [ssa_pkg::COEF_W-1:0]   req_coef_b,
   input  wire logic signed [ssa_pkg::COEF_W-1:0]   req_coef_c,
   input  wire logic signed [ssa_pkg::COEF_W-1:0]   req_coef_d,
   output logic                                     rsp_valid,
   output logic             [ssa_pkg::STATUS_W-1:0] rsp_status,
   output logic             [ssa_pkg::GRANT_W-1:0]  rsp_granted_slot,
   output logic             [ssa_pkg::ATTR_W-1:0]   rsp_read_attributes,
   output logic signed      [ssa_pkg::COEF_W-1:0]   rsp_read_rotation
);

   import ssa_pkg::*;

   ctl_cmd_type   ctl_cmd;
   dp_status_type dp_status;

   ssa_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .start       (start),
      .req_command (req_command),
      .dp_status   (dp_status),
      .busy        (busy),
      .ctl_cmd     (ctl_cmd)
   );

   ssa_datapath #(
      .SLOT_COUNT  (SLOT_COUNT),
      .GROUP_COUNT (GROUP_COUNT)
   ) u_datapath (
      .clock               (clock),
      .reset               (reset),
      .ctl_cmd             (ctl_cmd),
      .dp_status           (dp_status),
      .req_attributes      (req_attributes),
      .req_slot_index      (req_slot_index),
      .req_group_index     (req_group_index),
      .req_coef_a          (req_coef_a),
      .req_coef_b          (req_coef_b),
      .req_coef_c          (req_coef_c),
      .req_coef_d          (req_coef_d),
      .rsp_valid           (rsp_valid),
      .rsp_status          (rsp_status),
      .rsp_granted_slot    (rsp_granted_slot),
      .rsp_read_attributes (rsp_read_attributes),
      .rsp_read_rotation   (rsp_read_rotation)
   );

endmodule

`default_nettype wire

FILE: hdl/ssa_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
`default_nettype none

module ssa_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 32,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic             clock,
   input  wire logic             wr_en,
   input  wire logic [AW-1:0]    wr_addr,
   input  wire logic [WIDTH-1:0] wr_data,
   input  wire logic [AW-1:0]    rd_addr,
   output logic      [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

FILE: hdl/ssa_ctrl.sv
// Controller: two-state sequencer that decodes the command and steers the datapath.
`default_nettype none

module ssa_ctrl (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         start,
   input  wire logic [ssa_pkg::CMD_W-1:0]    req_command,
   input  wire ssa_pkg::dp_status_type       dp_status,
   output logic                              busy,
   output ssa_pkg::ctl_cmd_type              ctl_cmd
);

   import ssa_pkg::*;

   localparam logic STATE_IDLE   = 1'b0;
   localparam logic STATE_FINISH = 1'b1;

   logic             state_ff;
   logic             state_in;
   logic [CMD_W-1:0] cmd_ff;
   logic [CMD_W-1:0] cmd_in;
   logic             capture;

   assign busy    = (state_ff == STATE_FINISH);
   assign capture = start && !busy;

   always_comb begin
      state_in = state_ff;
      cmd_in   = cmd_ff;
      unique case (state_ff)
         STATE_IDLE: begin
            if (capture) begin
               state_in = STATE_FINISH;
               cmd_in   = req_command;
            end
         end
         STATE_FINISH: begin
            state_in = STATE_IDLE;
         end
         default: begin
            state_in = STATE_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= STATE_IDLE;
         cmd_ff   <= CMD_ALLOC;
      end else begin
         state_ff <= state_in;
         cmd_ff   <= cmd_in;
      end
   end

   always_comb begin
      ctl_cmd          = '0;
      ctl_cmd.capture  = capture;
      ctl_cmd.status   = RSP_OK;
      if (busy) begin
         ctl_cmd.rsp_load = 1'b1;
         unique case (cmd_ff)
            CMD_ALLOC: begin
               if (dp_status.table_full) begin
                  ctl_cmd.status = RSP_FULL;
               end else begin
                  ctl_cmd.alloc_wr  = 1'b1;
                  ctl_cmd.alloc_out = 1'b1;
               end
            end
            CMD_FREE: begin
               ctl_cmd.slot_out = 1'b1;
               if (!dp_status.slot_in_range) begin
                  ctl_cmd.status = RSP_RANGE;
               end else if (!dp_status.slot_used) begin
                  ctl_cmd.status = RSP_NOT_ALLOC;
               end else begin
                  ctl_cmd.free_wr = 1'b1;
               end
            end
            CMD_ROT: begin
               ctl_cmd.rot_wr = dp_status.group_in_range;
            end
            CMD_READ: begin
               ctl_cmd.slot_out = 1'b1;
               if (!dp_status.slot_in_range) begin
                  ctl_cmd.status = RSP_RANGE;
               end else begin
                  ctl_cmd.read_out = 1'b1;
               end
            end
            CMD_CLEAR: begin
               ctl_cmd.clear_all = 1'b1;
            end
            default: begin
               ctl_cmd.status = RSP_OK;
            end
         endcase
      end
   end

`ifndef SYNTHESIS
   a_finish_one_cycle: assert property (@(posedge clock) disable iff (reset)
      busy |=> !busy)
      else $error("controller stayed busy past one cycle");

   a_accept_goes_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("accepted item did not start work");

   a_one_write: assert property (@(posedge clock) disable iff (reset)
      $onehot0({ctl_cmd.alloc_wr, ctl_cmd.free_wr, ctl_cmd.rot_wr, ctl_cmd.clear_all}))
      else $error("more than one state update in one cycle");
`endif

endmodule

`default_nettype wire

FILE: hdl/ssa_datapath.sv
// Datapath: occupancy bitmap, free-slot search, attribute and rotation stores, result registers.
`default_nettype none

module ssa_datapath #(
   parameter int SLOT_COUNT  = ssa_pkg::SLOT_COUNT_DEF,
   parameter int GROUP_COUNT = ssa_pkg::GROUP_COUNT_DEF
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire ssa_pkg::ctl_cmd_type                ctl_cmd,
   output ssa_pkg::dp_status_type                   dp_status,
   input  wire logic        [ssa_pkg::ATTR_W-1:0]   req_attributes,
   input  wire logic        [ssa_pkg::SLOT_W-1:0]   req_slot_index,
   input  wire logic        [ssa_pkg::GROUP_W-1:0]  req_group_index,
   input  wire logic signed [ssa_pkg::COEF_W-1:0]   req_coef_a,
   input  wire logic signed [ssa_pkg::COEF_W-1:0]   req_coef_b,
   input  wire logic signed [ssa_pkg::COEF_W-1:0]   req_coef_c,
   input  wire logic signed [ssa_pkg::COEF_W-1:0]   req_coef_d,
   output logic                                     rsp_valid,
   output logic             [ssa_pkg::STATUS_W-1:0] rsp_status,
   output logic             [ssa_pkg::GRANT_W-1:0]  rsp_granted_slot,
   output logic             [ssa_pkg::ATTR_W-1:0]   rsp_read_attributes,
   output logic signed      [ssa_pkg::COEF_W-1:0]   rsp_read_rotation
);

   import ssa_pkg::*;

   localparam int SLOT_AW   = $clog2(SLOT_COUNT);
   localparam int GRP_AW    = (GROUP_COUNT > 1) ? $clog2(GROUP_COUNT) : 1;
   localparam int NUM_CHUNK = (SLOT_COUNT + CHUNK_BITS - 1) / CHUNK_BITS;
   localparam int PAD_W     = NUM_CHUNK * CHUNK_BITS;
   localparam int FOUND_W   = $clog2(PAD_W);

   // Request payload
   logic [SLOT_W-1:0]  slot_q;
   logic [GROUP_W-1:0] group_q;
   logic [ATTR_W-1:0]  attr_q;
   logic [ROT_W-1:0]   coef_q;

   // Occupancy and rotation group valid bits
   logic [SLOT_COUNT-1:0]  occ_ff;
   logic [SLOT_COUNT-1:0]  occ_in;
   logic [GROUP_COUNT-1:0] rot_vld_ff;
   logic [GROUP_COUNT-1:0] rot_vld_in;

   // Free-slot search, first level registered at accept
   logic [PAD_W-1:0]       occ_pad;
   logic [NUM_CHUNK-1:0]   chunk_free_ff;
   logic [NUM_CHUNK-1:0]   chunk_free_in;
   logic [CHUNK_IDX_W-1:0] chunk_idx_ff [NUM_CHUNK];
   logic [CHUNK_IDX_W-1:0] chunk_idx_in [NUM_CHUNK];
   logic                   found_free;
   logic [FOUND_W-1:0]     found_slot;
   logic [SLOT_AW-1:0]     found_addr;

   logic [SLOT_AW-1:0] slot_addr;
   logic [GRP_AW-1:0]  group_addr;
   logic               slot_in_range;
   logic               slot_used;
   logic               group_in_range;
   logic               rd_grp_ok;
   logic [ATTR_W-1:0]  attr_rd;
   logic [ROT_W-1:0]   rot_rd;
   logic [COEF_W-1:0]  coef_sel;

   // Result registers
   logic                rsp_valid_ff;
   logic [STATUS_W-1:0] rsp_status_ff;
   logic [GRANT_W-1:0]  rsp_granted_ff;
   logic [ATTR_W-1:0]   rsp_attr_ff;
   logic [COEF_W-1:0]   rsp_rot_ff;
   logic [GRANT_W-1:0]  granted_in;
   logic [ATTR_W-1:0]   attr_out_in;
   logic [COEF_W-1:0]   rot_out_in;

   always_ff @(posedge clock) begin
      if (ctl_cmd.capture) begin
         slot_q  <= req_slot_index;
         group_q <= req_group_index;
         attr_q  <= req_attributes;
         coef_q  <= {req_coef_d, req_coef_c, req_coef_b, req_coef_a};
      end
   end

   // First search level: lowest free bit within each chunk; pad bits count as used
   always_comb begin
      occ_pad                 = '1;
      occ_pad[SLOT_COUNT-1:0] = occ_ff;
      for (int c = 0; c < NUM_CHUNK; c++) begin
         chunk_free_in[c] = ~&occ_pad[c*CHUNK_BITS +: CHUNK_BITS];
         chunk_idx_in[c]  = '0;
         for (int b = CHUNK_BITS - 1; b >= 0; b--) begin
            if (!occ_pad[c*CHUNK_BITS + b]) begin
               chunk_idx_in[c] = CHUNK_IDX_W'(b);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      chunk_free_ff <= chunk_free_in;
      chunk_idx_ff  <= chunk_idx_in;
   end

   // Second level: lowest chunk with a free bit
   always_comb begin
      found_free = 1'b0;
      found_slot = '0;
      for (int c = NUM_CHUNK - 1; c >= 0; c--) begin
         if (chunk_free_ff[c]) begin
            found_free = 1'b1;
            found_slot = FOUND_W'(c * CHUNK_BITS + int'(chunk_idx_ff[c]));
         end
      end
   end

   assign found_addr     = SLOT_AW'(found_slot);
   assign slot_addr      = SLOT_AW'(slot_q);
   assign group_addr     = GRP_AW'(group_q);
   assign slot_in_range  = 32'(slot_q) < 32'(SLOT_COUNT);
   assign slot_used      = slot_in_range && occ_ff[slot_addr];
   assign group_in_range = 32'(group_q) < 32'(GROUP_COUNT);
   assign rd_grp_ok      = (32'(slot_q[SLOT_W-1:2]) < 32'(GROUP_COUNT))
                           && rot_vld_ff[GRP_AW'(slot_q[SLOT_W-1:2])];

   always_comb begin
      dp_status                = '0;
      dp_status.table_full     = !found_free;
      dp_status.slot_in_range  = slot_in_range;
      dp_status.slot_used      = slot_used;
      dp_status.group_in_range = group_in_range;
   end

   always_comb begin
      occ_in     = occ_ff;
      rot_vld_in = rot_vld_ff;
      if (ctl_cmd.clear_all) begin
         occ_in     = '0;
         rot_vld_in = '0;
      end else begin
         if (ctl_cmd.alloc_wr) begin
            occ_in[found_addr] = 1'b1;
         end
         if (ctl_cmd.free_wr) begin
            occ_in[slot_addr] = 1'b0;
         end
         if (ctl_cmd.rot_wr) begin
            rot_vld_in[group_addr] = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         occ_ff     <= '0;
         rot_vld_ff <= '0;
      end else begin
         occ_ff     <= occ_in;
         rot_vld_ff <= rot_vld_in;
      end
   end

   // Entries of a free slot or an unwritten group never reach the output,
   // so neither store needs clearing.
   ssa_ram #(
      .WIDTH (ATTR_W),
      .DEPTH (SLOT_COUNT)
   ) u_attr_ram (
      .clock   (clock),
      .wr_en   (ctl_cmd.alloc_wr),
      .wr_addr (found_addr),
      .wr_data (attr_q),
      .rd_addr (SLOT_AW'(req_slot_index)),
      .rd_data (attr_rd)
   );

   ssa_ram #(
      .WIDTH (ROT_W),
      .DEPTH (GROUP_COUNT)
   ) u_rot_ram (
      .clock   (clock),
      .wr_en   (ctl_cmd.rot_wr),
      .wr_addr (group_addr),
      .wr_data (coef_q),
      .rd_addr (GRP_AW'(req_slot_index[SLOT_W-1:2])),
      .rd_data (rot_rd)
   );

   always_comb begin
      unique case (slot_q[1:0])
         2'd0: coef_sel = rot_rd[0*COEF_W +: COEF_W];
         2'd1: coef_sel = rot_rd[1*COEF_W +: COEF_W];
         2'd2: coef_sel = rot_rd[2*COEF_W +: COEF_W];
         2'd3: coef_sel = rot_rd[3*COEF_W +: COEF_W];
         default: coef_sel = '0;
      endcase
   end

   always_comb begin
      priority if (ctl_cmd.alloc_out) begin
         granted_in = GRANT_W'(found_slot);
      end else if (ctl_cmd.slot_out) begin
         granted_in = slot_q[GRANT_W-1:0];
      end else begin
         granted_in = '0;
      end
      attr_out_in = (ctl_cmd.read_out && slot_used) ? attr_rd : '0;
      rot_out_in  = (ctl_cmd.read_out && rd_grp_ok) ? coef_sel : '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= ctl_cmd.rsp_load;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl_cmd.rsp_load) begin
         rsp_status_ff  <= ctl_cmd.status;
         rsp_granted_ff <= granted_in;
         rsp_attr_ff    <= attr_out_in;
         rsp_rot_ff     <= rot_out_in;
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_status          = rsp_status_ff;
   assign rsp_granted_slot    = rsp_granted_ff;
   assign rsp_read_attributes = rsp_attr_ff;
   assign rsp_read_rotation   = rsp_rot_ff;

`ifndef SYNTHESIS
   a_alloc_free_slot: assert property (@(posedge clock) disable iff (reset)
      ctl_cmd.alloc_wr |-> !occ_ff[found_addr])
      else $error("allocate picked an occupied slot");

   a_clear_empties: assert property (@(posedge clock) disable iff (reset)
      ctl_cmd.clear_all |=> (occ_ff == '0) && (rot_vld_ff == '0))
      else $error("clear all left state behind");

   a_full_grants_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_status == RSP_FULL)) |-> (rsp_granted_slot == '0))
      else $error("full result carries a slot");
`endif

endmodule

`default_nettype wire

FILE: bench/sprite_slot_allocator_core_tb.sv
// Self-checking testbench for the sprite slot allocator core: directed and random command items.
module sprite_slot_allocator_core_tb;
   import ssa_pkg::*;

   localparam int SLOTS         = SLOT_COUNT_DEF;
   localparam int GROUPS        = GROUP_COUNT_DEF;
   localparam int NO_IDLE_TAIL  = 200;
   localparam int QUIET_LIMIT   = 400;
   localparam int DRAIN_CYCLES  = 10;

   // command codes the block does not implement
   localparam logic [CMD_W-1:0] CMD_RSVD5 = 3'd5;
   localparam logic [CMD_W-1:0] CMD_RSVD6 = 3'd6;
   localparam logic [CMD_W-1:0] CMD_RSVD7 = 3'd7;

   typedef struct {
      logic [CMD_W-1:0]          command;
      logic [ATTR_W-1:0]         attributes;
      logic [SLOT_W-1:0]         slot_index;
      logic [GROUP_W-1:0]        group_index;
      logic signed [COEF_W-1:0]  coef_a;
      logic signed [COEF_W-1:0]  coef_b;
      logic signed [COEF_W-1:0]  coef_c;
      logic signed [COEF_W-1:0]  coef_d;
   } sprite_cmd_type;

   typedef struct {
      logic [STATUS_W-1:0]       status;
      logic [GRANT_W-1:0]        granted_slot;
      logic [ATTR_W-1:0]         read_attributes;
      logic signed [COEF_W-1:0]  read_rotation;
   } slot_reply_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic busy;
   logic [CMD_W-1:0]         req_command     = '0;
   logic [ATTR_W-1:0]        req_attributes  = '0;
   logic [SLOT_W-1:0]        req_slot_index  = '0;
   logic [GROUP_W-1:0]       req_group_index = '0;
   logic signed [COEF_W-1:0] req_coef_a      = '0;
   logic signed [COEF_W-1:0] req_coef_b      = '0;
   logic signed [COEF_W-1:0] req_coef_c      = '0;
   logic signed [COEF_W-1:0] req_coef_d      = '0;
   logic                     rsp_valid;
   logic [STATUS_W-1:0]      rsp_status;
   logic [GRANT_W-1:0]       rsp_granted_slot;
   logic [ATTR_W-1:0]        rsp_read_attributes;
   logic signed [COEF_W-1:0] rsp_read_rotation;

   sprite_cmd_type pending_cmds[$];
   slot_reply_type expected_replies[$];
   sprite_cmd_type on_port;
   int          error_count = 0;
   int          sent_count  = 0;
   int          idle_left   = 0;
   int          idle_pct    = 20;
   int          quiet_cycles = 0;

   // predictor state
   bit                slot_used_map[SLOTS];
   logic [ATTR_W-1:0] slot_attr_mem[SLOTS];
   logic [ROT_W-1:0]  rot_group_mem[GROUPS];

   sprite_slot_allocator_core u_dut (
      .clock               (clock),
      .reset               (reset),
      .start               (start),
      .busy                (busy),
      .req_command         (req_command),
      .req_attributes      (req_attributes),
      .req_slot_index      (req_slot_index),
      .req_group_index     (req_group_index),
      .req_coef_a          (req_coef_a),
      .req_coef_b          (req_coef_b),
      .req_coef_c          (req_coef_c),
      .req_coef_d          (req_coef_d),
      .rsp_valid           (rsp_valid),
      .rsp_status          (rsp_status),
      .rsp_granted_slot    (rsp_granted_slot),
      .rsp_read_attributes (rsp_read_attributes),
      .rsp_read_rotation   (rsp_read_rotation)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic void clear_table();
      for (int s = 0; s < SLOTS; s++) begin
         slot_used_map[s] = 1'b0;
         slot_attr_mem[s] = '0;
      end
      for (int g = 0; g < GROUPS; g++) rot_group_mem[g] = '0;
   endfunction

   // Applies one command to the predicted table and returns the reply it should give.
   function automatic slot_reply_type compute_reply(sprite_cmd_type c);
      slot_reply_type r;
      bit          found;
      int          s;
      int          g;
      r.status          = RSP_OK;
      r.granted_slot    = '0;
      r.read_attributes = '0;
      r.read_rotation   = '0;
      found             = 1'b0;
      s                 = c.slot_index;
      case (c.command)
         CMD_ALLOC: begin
            for (int k = 0; k < SLOTS && !found; k++) begin
               if (!slot_used_map[k]) begin
                  found            = 1'b1;
                  slot_used_map[k] = 1'b1;
                  slot_attr_mem[k] = c.attributes;
                  r.granted_slot   = k[GRANT_W-1:0];
               end
            end
            if (!found) r.status = RSP_FULL;
         end
         CMD_FREE: begin
            r.granted_slot = c.slot_index[GRANT_W-1:0];
            if (s >= SLOTS) r.status = RSP_RANGE;
            else if (!slot_used_map[s]) r.status = RSP_NOT_ALLOC;
            else begin
               slot_used_map[s] = 1'b0;
               slot_attr_mem[s] = '0;   // rotation group is kept
            end
         end
         CMD_ROT: begin
            if (c.group_index < GROUPS)
               rot_group_mem[c.group_index] = {c.coef_d, c.coef_c, c.coef_b, c.coef_a};
         end
         CMD_READ: begin
            r.granted_slot = c.slot_index[GRANT_W-1:0];
            if (s >= SLOTS) r.status = RSP_RANGE;
            else begin
               g = s / 4;
               r.read_attributes = slot_attr_mem[s];
               if (g < GROUPS) r.read_rotation = rot_group_mem[g][COEF_W*(s%4) +: COEF_W];
            end
         end
         CMD_CLEAR: clear_table();
         default: ;
      endcase
      return r;
   endfunction

   function automatic sprite_cmd_type random_cmd(logic [CMD_W-1:0] command);
      sprite_cmd_type c;
      c.command     = command;
      c.attributes  = ATTR_W'({$urandom(), $urandom()});
      c.slot_index  = SLOT_W'($urandom());
      c.group_index = GROUP_W'($urandom());
      c.coef_a      = COEF_W'($urandom());
      c.coef_b      = COEF_W'($urandom());
      c.coef_c      = COEF_W'($urandom());
      c.coef_d      = COEF_W'($urandom());
      return c;
   endfunction

   task automatic add_cmd(logic [CMD_W-1:0] command, logic [SLOT_W-1:0] slot);
      sprite_cmd_type c;
      c            = random_cmd(command);
      c.slot_index = slot;
      pending_cmds.push_back(c);
   endtask

   task automatic add_alloc(logic [ATTR_W-1:0] attrs);
      sprite_cmd_type c;
      c            = random_cmd(CMD_ALLOC);
      c.attributes = attrs;
      pending_cmds.push_back(c);
   endtask

   task automatic add_rot(logic [GROUP_W-1:0] grp, logic signed [COEF_W-1:0] a,
                          logic signed [COEF_W-1:0] b, logic signed [COEF_W-1:0] c,
                          logic signed [COEF_W-1:0] d);
      sprite_cmd_type it;
      it             = random_cmd(CMD_ROT);
      it.group_index = grp;
      it.coef_a      = a;
      it.coef_b      = b;
      it.coef_c      = c;
      it.coef_d      = d;
      pending_cmds.push_back(it);
   endtask

   // Random phase; each percentage is one command's share, summed into thresholds; the rest
   // are unimplemented commands.
   task automatic add_phase(int count, int p_alloc, int p_free, int p_rot, int p_read,
                            int p_clear);
      sprite_cmd_type c;
      int          roll;
      for (int n = 0; n < count; n++) begin
         roll = $urandom_range(0, 99);
         if (roll < p_alloc) c = random_cmd(CMD_ALLOC);
         else if (roll < p_alloc + p_free) c = random_cmd(CMD_FREE);
         else if (roll < p_alloc + p_free + p_rot) c = random_cmd(CMD_ROT);
         else if (roll < p_alloc + p_free + p_rot + p_read) c = random_cmd(CMD_READ);
         else if (roll < p_alloc + p_free + p_rot + p_read + p_clear)
            c = random_cmd(CMD_CLEAR);
         else c = random_cmd(CMD_W'(CMD_RSVD5 + $urandom_range(0, 2)));
         // mostly in-range slots so frees and reads hit the table
         if ((c.command == CMD_FREE || c.command == CMD_READ) && $urandom_range(0, 99) < 85)
            c.slot_index = SLOT_W'($urandom_range(0, SLOTS - 1));
         pending_cmds.push_back(c);
      end
   endtask

   initial begin
      clear_table();
      // directed part
      add_cmd(CMD_READ, 8'd0);
      add_alloc({ATTR_W{1'b1}});
      add_alloc('0);
      add_cmd(CMD_READ, 8'd0);
      add_rot(5'd0, -16'sd32768, 16'sd32767, -16'sd1, 16'sd0);
      add_cmd(CMD_READ, 8'd0);
      add_cmd(CMD_READ, 8'd1);
      add_cmd(CMD_READ, 8'd2);
      add_cmd(CMD_READ, 8'd3);
      add_rot(5'd31, 16'sd32767, -16'sd32768, 16'sd1, -16'sd2);
      add_cmd(CMD_READ, 8'd127);
      add_cmd(CMD_READ, 8'd124);
      add_cmd(CMD_FREE, 8'd1);
      add_cmd(CMD_FREE, 8'd1);
      add_cmd(CMD_READ, 8'd1);
      add_cmd(CMD_FREE, 8'd128);
      add_cmd(CMD_FREE, 8'd255);
      add_cmd(CMD_READ, 8'd128);
      add_cmd(CMD_READ, 8'd255);
      add_alloc(48'h5555_aaaa_5555);
      add_cmd(CMD_RSVD5, 8'd0);
      add_cmd(CMD_RSVD6, 8'd0);
      add_cmd(CMD_RSVD7, 8'd0);
      add_cmd(CMD_CLEAR, 8'd0);
      add_cmd(CMD_READ, 8'd0);
      // random part: fill to full, then drain, several rounds
      for (int round = 0; round < 4; round++) begin
         add_phase(260, 65, 8, 8, 14, 0);
         add_phase(150, 10, 55, 8, 20, 2);
      end
      add_phase(85, 30, 30, 10, 20, 5);

      repeat (6) @(posedge clock);
      reset <= 1'b0;

      while (pending_cmds.size() != 0 || start || expected_replies.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (error_count == 0) $display("** sprite_slot_allocator_core: PASSED **");
      else $display("** sprite_slot_allocator_core: FAILED **");
      $finish;
   end

   // driver
   always @(posedge clock) begin
      if (reset) begin
         start <= 1'b0;
         idle_left = 0;
      end else begin
         if (start && !busy) begin
            expected_replies.push_back(compute_reply(on_port));
            sent_count++;
            if (sent_count % 100 == 0) idle_pct = $urandom_range(0, 2) * 20;
         end
         if (!(start && busy)) begin
            if (idle_left > 0) begin
               idle_left--;
               start <= 1'b0;
            end else if (pending_cmds.size() > NO_IDLE_TAIL &&
                         $urandom_range(0, 99) < idle_pct) begin
               idle_left = $urandom_range(0, 14);   // start an idle burst
               start <= 1'b0;
            end else if (pending_cmds.size() != 0) begin
               on_port = pending_cmds.pop_front();
               req_command     <= on_port.command;
               req_attributes  <= on_port.attributes;
               req_slot_index  <= on_port.slot_index;
               req_group_index <= on_port.group_index;
               req_coef_a      <= on_port.coef_a;
               req_coef_b      <= on_port.coef_b;
               req_coef_c      <= on_port.coef_c;
               req_coef_d      <= on_port.coef_d;
               start <= 1'b1;
            end else begin
               start <= 1'b0;
            end
         end
      end
   end

   // monitor
   always @(posedge clock) begin
      slot_reply_type want;
      if (!reset && rsp_valid) begin
         if (expected_replies.size() == 0) begin
            $error("result with no item outstanding: status %0d slot %0d",
                   rsp_status, rsp_granted_slot);
            error_count++;
         end else begin
            want = expected_replies.pop_front();
            if (rsp_status !== want.status) begin
               $error("status: expected %0d, actual %0d", want.status, rsp_status);
               error_count++;
            end
            if (rsp_granted_slot !== want.granted_slot) begin
               $error("granted_slot: expected %0d, actual %0d",
                      want.granted_slot, rsp_granted_slot);
               error_count++;
            end
            if (rsp_read_attributes !== want.read_attributes) begin
               $error("read_attributes: expected %h, actual %h",
                      want.read_attributes, rsp_read_attributes);
               error_count++;
            end
            if (rsp_read_rotation !== want.read_rotation) begin
               $error("read_rotation: expected %0d, actual %0d",
                      want.read_rotation, rsp_read_rotation);
               error_count++;
            end
         end
      end
   end

   // watchdog: cycles with neither an accepted item nor a result
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("** sprite_slot_allocator_core: FAILED **");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

endmodule
